// File: rtl/core/atrp_pkg.sv
`timescale 1ns / 1ps
package atrp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic       store_write;
    logic [3:0] store_line;
    logic [6:0] store_column;
    logic [7:0] store_byte;
    logic [4:0] lines_captured;
  } result_t;

endpackage

// File: rtl/core/atrp_line_mem.sv
`timescale 1ns / 1ps
module atrp_line_mem #(
  parameter int MAX_LINES  = 16,
  parameter int LINE_BYTES = 128,
  parameter int LW         = 4,
  parameter int COLW       = 7
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [LW-1:0]   wr_line,
  input  logic [COLW-1:0] wr_col,
  input  logic [7:0]      wr_data
);

  logic [7:0] mem [MAX_LINES][LINE_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_line][wr_col] <= wr_data;
    end
  end

endmodule

// File: rtl/core/atrp_parser.sv
`timescale 1ns / 1ps
module atrp_parser #(
  parameter int MAX_LINES  = 16,
  parameter int LINE_BYTES = 128,
  parameter int LW         = 4,
  parameter int COLW       = 7,
  parameter int CW         = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output atrp_pkg::result_t result,
  output logic              wr_en,
  output logic [LW-1:0]     wr_line,
  output logic [COLW-1:0]   wr_col,
  output logic [7:0]        wr_data
);
  import atrp_pkg::*;

  typedef enum logic [4:0] {
    P_START, P_LF0, P_FIRST, P_LINE_FIRST, P_LINE_BODY, P_LINE_LF,
    P_NEXT, P_BLANK_LF, P_FINAL,
    P_OK_K, P_OK_CR, P_OK_LF,
    P_ER_R1, P_ER_R2, P_ER_O, P_ER_R3, P_ER_CR, P_ER_LF
  } pstate_t;

  localparam logic [COLW-1:0] COL_LAST = COLW'(LINE_BYTES - 1);
  localparam logic [CW-1:0]   CNT_MAX  = CW'(MAX_LINES);

  pstate_t          state, state_next;
  logic [COLW-1:0]  col, col_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [1:0]       st;
  logic             put;
  logic [COLW-1:0]  put_col;
  logic [7:0]       put_byte;
  logic [31:0]      line_ext, col_ext, cap_ext;

  always_comb begin
    state_next = state;
    col_next   = col;
    cnt_next   = cnt;
    st         = ST_ERR;
    put        = 1'b0;
    put_col    = '0;
    put_byte   = '0;
    unique case (state)
      P_START: if (rx_byte == CH_CR) begin state_next = P_LF0; st = ST_BUSY; end
      P_LF0:   if (rx_byte == CH_LF) begin state_next = P_FIRST; st = ST_BUSY; end
      P_FIRST, P_NEXT: begin
        if (rx_byte == CH_PLUS) begin
          if (cnt < CNT_MAX) begin
            state_next = P_LINE_FIRST;
            st = ST_BUSY;
          end
        end else if (state == P_NEXT && rx_byte == CH_CR) begin
          state_next = P_BLANK_LF;
          st = ST_BUSY;
        end else if (state == P_FIRST && rx_byte == CH_O) begin
          state_next = P_OK_K;
          st = ST_BUSY;
        end else if (state == P_FIRST && rx_byte == CH_E) begin
          state_next = P_ER_R1;
          st = ST_BUSY;
        end
      end
      P_LINE_FIRST: begin
        if (rx_byte != CH_LF) begin
          put        = 1'b1;
          put_byte   = rx_byte;
          col_next   = COLW'(1);
          state_next = P_LINE_BODY;
          st         = ST_BUSY;
        end
      end
      P_LINE_BODY: begin
        if (rx_byte == CH_CR) begin
          put        = 1'b1;
          put_col    = col;
          cnt_next   = cnt + CW'(1);
          col_next   = '0;
          state_next = P_LINE_LF;
          st         = ST_BUSY;
        end else if (rx_byte != CH_LF) begin
          put = 1'b1;
          st  = ST_BUSY;
          if (col < COL_LAST) begin
            put_col  = col;
            put_byte = rx_byte;
            col_next = col + COLW'(1);
          end else begin
            put_col  = COL_LAST;
          end
        end
      end
      P_LINE_LF:  if (rx_byte == CH_LF) begin state_next = P_NEXT; st = ST_BUSY; end
      P_BLANK_LF: if (rx_byte == CH_LF) begin state_next = P_FINAL; st = ST_BUSY; end
      P_FINAL: begin
        if (rx_byte == CH_O) begin
          state_next = P_OK_K;
          st = ST_BUSY;
        end else if (rx_byte == CH_E) begin
          state_next = P_ER_R1;
          st = ST_BUSY;
        end
      end
      P_OK_K:  if (rx_byte == CH_K) begin state_next = P_OK_CR; st = ST_BUSY; end
      P_OK_CR: if (rx_byte == CH_CR) begin state_next = P_OK_LF; st = ST_BUSY; end
      P_OK_LF: if (rx_byte == CH_LF) st = ST_OK;
      P_ER_R1: if (rx_byte == CH_R) begin state_next = P_ER_R2; st = ST_BUSY; end
      P_ER_R2: if (rx_byte == CH_R) begin state_next = P_ER_O; st = ST_BUSY; end
      P_ER_O:  if (rx_byte == CH_O) begin state_next = P_ER_R3; st = ST_BUSY; end
      P_ER_R3: if (rx_byte == CH_R) begin state_next = P_ER_CR; st = ST_BUSY; end
      P_ER_CR: if (rx_byte == CH_CR) begin state_next = P_ER_LF; st = ST_BUSY; end
      P_ER_LF: st = ST_ERR;
      default: st = ST_ERR;
    endcase
  end

  // outputs use low bits of the counts
  assign line_ext = 32'(cnt);
  assign col_ext  = 32'(put_col);
  assign cap_ext  = 32'(cnt_next);

  always_comb begin
    result.status         = st;
    result.store_write    = put;
    result.store_line     = put ? line_ext[3:0] : 4'd0;
    result.store_column   = put ? col_ext[6:0] : 7'd0;
    result.store_byte     = put_byte;
    result.lines_captured = cap_ext[4:0];
  end

  assign wr_en   = accept && put;
  assign wr_line = cnt[LW-1:0];
  assign wr_col  = put_col;
  assign wr_data = put_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_START;
      col   <= '0;
      cnt   <= '0;
    end else if (accept) begin
      if (st != ST_BUSY) begin
        state <= P_START;
        col   <= '0;
        cnt   <= '0;
      end else begin
        state <= state_next;
        col   <= col_next;
        cnt   <= cnt_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    accept && result.store_write |-> result.status == ST_BUSY)
    else $error("store write with final status");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX && col <= COL_LAST)
    else $error("line or column count out of range");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    accept && result.status != ST_BUSY |=> state == P_START && cnt == '0 && col == '0)
    else $error("counts not cleared after final status");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(cnt) && $stable(col))
    else $error("counts changed without a transfer");
`endif

endmodule

// File: rtl/core/atrp_out_buf.sv
`timescale 1ns / 1ps
module atrp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  atrp_pkg::result_t in_res,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output atrp_pkg::result_t out_res
);
  import atrp_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    drain;

  assign full  = skid_valid;
  assign drain = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_res <= skid_valid ? skid : in_res;
    end else if (accept) begin
      skid <= in_res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data while output is empty");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && !accept |=> out_valid && $stable(out_res))
    else $error("stalled result lost");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !accept)
    else $error("transfer taken while skid full");
`endif

endmodule

// File: rtl/core/at_response_parser_top.sv
`timescale 1ns / 1ps
// each accepted byte's result is registered in the output register or skid
// throughput: one byte per cycle while the skid entry is free
// an output register plus one skid entry keep input open while a result waits
// the line store is written only within plus lines and needs no clearing pass
// rst (synchronous) returns the parser to its start with counts cleared
module at_response_parser_top #(
  parameter int MAX_LINES  = 16,
  parameter int LINE_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic       store_write,
  output logic [3:0] store_line,
  output logic [6:0] store_column,
  output logic [7:0] store_byte,
  output logic [4:0] lines_captured
);
  import atrp_pkg::*;

  localparam int LW   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int COLW = $clog2(LINE_BYTES);
  localparam int CW   = $clog2(MAX_LINES + 1);

  logic            accept;
  logic            buf_full;
  result_t         res, res_q;
  logic            wr_en;
  logic [LW-1:0]   wr_line;
  logic [COLW-1:0] wr_col;
  logic [7:0]      wr_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  atrp_parser #(
    .MAX_LINES (MAX_LINES),
    .LINE_BYTES(LINE_BYTES),
    .LW        (LW),
    .COLW      (COLW),
    .CW        (CW)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .rx_byte(rx_byte),
    .result (res),
    .wr_en  (wr_en),
    .wr_line(wr_line),
    .wr_col (wr_col),
    .wr_data(wr_data)
  );

  atrp_line_mem #(
    .MAX_LINES (MAX_LINES),
    .LINE_BYTES(LINE_BYTES),
    .LW        (LW),
    .COLW      (COLW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_line(wr_line),
    .wr_col (wr_col),
    .wr_data(wr_data)
  );

  atrp_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_res   (res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (res_q)
  );

  assign status         = res_q.status;
  assign store_write    = res_q.store_write;
  assign store_line     = res_q.store_line;
  assign store_column   = res_q.store_column;
  assign store_byte     = res_q.store_byte;
  assign lines_captured = res_q.lines_captured;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import atrp_pkg::*;

  localparam int N_LINES        = 16;
  localparam int N_BYTES        = 128;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [4:0] {
    PS_START, PS_LF0, PS_FIRST, PS_LINE_FIRST, PS_LINE_BODY, PS_LINE_LF,
    PS_NEXT, PS_BLANK_LF, PS_FINAL,
    PS_OK_K, PS_OK_CR, PS_OK_LF,
    PS_ER_R1, PS_ER_R2, PS_ER_O, PS_ER_R3, PS_ER_CR, PS_ER_LF
  } parse_state_t;

  class response_scoreboard;
    parse_state_t pstate;
    int col_cnt;
    int line_cnt;
    int errors;
    result_t expected_q[$];

    function new();
      pstate = PS_START;
      col_cnt = 0;
      line_cnt = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function result_t store_entry(int col, logic [7:0] b);
      result_t r;
      r = '0;
      r.store_write = 1'b1;
      r.store_line = 4'(line_cnt);
      r.store_column = 7'(col);
      r.store_byte = b;
      return r;
    endfunction

    // predicts the result of one accepted byte
    function void note_byte(logic [7:0] c);
      result_t r;
      logic [1:0] st;
      r = '0;
      st = ST_ERR;
      case (pstate)
        PS_START: if (c == CH_CR) begin
          pstate = PS_LF0;
          st = ST_BUSY;
        end
        PS_LF0: if (c == CH_LF) begin
          pstate = PS_FIRST;
          st = ST_BUSY;
        end
        PS_FIRST, PS_NEXT: begin
          if (c == CH_PLUS) begin
            if (line_cnt < N_LINES) begin
              pstate = PS_LINE_FIRST;
              st = ST_BUSY;
            end
          end else if (pstate == PS_NEXT && c == CH_CR) begin
            pstate = PS_BLANK_LF;
            st = ST_BUSY;
          end else if (pstate == PS_FIRST && c == CH_O) begin
            pstate = PS_OK_K;
            st = ST_BUSY;
          end else if (pstate == PS_FIRST && c == CH_E) begin
            pstate = PS_ER_R1;
            st = ST_BUSY;
          end
        end
        PS_LINE_FIRST: if (c != CH_LF) begin
          r = store_entry(0, c);
          col_cnt = 1;
          pstate = PS_LINE_BODY;
          st = ST_BUSY;
        end
        PS_LINE_BODY: begin
          if (c == CH_CR) begin
            r = store_entry(col_cnt, 8'h00);
            line_cnt++;
            col_cnt = 0;
            pstate = PS_LINE_LF;
            st = ST_BUSY;
          end else if (c != CH_LF) begin
            if (col_cnt < N_BYTES - 1) begin
              r = store_entry(col_cnt, c);
              col_cnt++;
            end else begin
              r = store_entry(N_BYTES - 1, 8'h00);
            end
            st = ST_BUSY;
          end
        end
        PS_LINE_LF: if (c == CH_LF) begin
          pstate = PS_NEXT;
          st = ST_BUSY;
        end
        PS_BLANK_LF: if (c == CH_LF) begin
          pstate = PS_FINAL;
          st = ST_BUSY;
        end
        PS_FINAL: begin
          if (c == CH_O) begin
            pstate = PS_OK_K;
            st = ST_BUSY;
          end else if (c == CH_E) begin
            pstate = PS_ER_R1;
            st = ST_BUSY;
          end
        end
        PS_OK_K: if (c == CH_K) begin
          pstate = PS_OK_CR;
          st = ST_BUSY;
        end
        PS_OK_CR: if (c == CH_CR) begin
          pstate = PS_OK_LF;
          st = ST_BUSY;
        end
        PS_OK_LF: if (c == CH_LF) begin
          st = ST_OK;
        end
        PS_ER_R1: if (c == CH_R) begin
          pstate = PS_ER_R2;
          st = ST_BUSY;
        end
        PS_ER_R2: if (c == CH_R) begin
          pstate = PS_ER_O;
          st = ST_BUSY;
        end
        PS_ER_O: if (c == CH_O) begin
          pstate = PS_ER_R3;
          st = ST_BUSY;
        end
        PS_ER_R3: if (c == CH_R) begin
          pstate = PS_ER_CR;
          st = ST_BUSY;
        end
        PS_ER_CR: if (c == CH_CR) begin
          pstate = PS_ER_LF;
          st = ST_BUSY;
        end
        default: begin
        end
      endcase
      r.status = st;
      r.lines_captured = 5'(line_cnt);
      if (st != ST_BUSY) begin
        pstate = PS_START;
        col_cnt = 0;
        line_cnt = 0;
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("store_write", 8'(want.store_write), 8'(got.store_write));
      compare_field("store_line", 8'(want.store_line), 8'(got.store_line));
      compare_field("store_column", 8'(want.store_column), 8'(got.store_column));
      compare_field("store_byte", want.store_byte, got.store_byte);
      compare_field("lines_captured", 8'(want.lines_captured), 8'(got.lines_captured));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] status;
  logic       store_write;
  logic [3:0] store_line;
  logic [6:0] store_column;
  logic [7:0] store_byte;
  logic [4:0] lines_captured;

  response_scoreboard sb;
  logic [7:0] byte_q[$];
  int results_seen;
  int quiet_cycles;

  at_response_parser_top #(
    .MAX_LINES(N_LINES),
    .LINE_BYTES(N_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .store_write(store_write),
    .store_line(store_line),
    .store_column(store_column),
    .store_byte(store_byte),
    .lines_captured(lines_captured)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function logic [7:0] noise_char();
    case ($urandom_range(9))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_PLUS;
      3: return CH_O;
      4: return CH_K;
      5: return CH_E;
      6: return CH_R;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task add_text(string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task add_crlf();
    byte_q.push_back(CH_CR);
    byte_q.push_back(CH_LF);
  endtask

  // one response: CR LF, optional plus lines and a blank line after them, then OK or ERROR
  task add_reply(int nlines, bit make_long, bit corrupt);
    int first;
    int len;
    int pos;
    first = byte_q.size();
    byte_q.push_back(CH_CR);
    byte_q.push_back(CH_LF);
    for (int n = 0; n < nlines; n++) begin
      if ((make_long && n == 0) || $urandom_range(99) < 2)
        len = $urandom_range(N_BYTES - 3, N_BYTES + 6);
      else
        len = $urandom_range(1, 12);
      byte_q.push_back(CH_PLUS);
      byte_q.push_back(($urandom_range(99) < 15) ? CH_CR : body_char());
      for (int k = 1; k < len; k++) byte_q.push_back(body_char());
      byte_q.push_back(CH_CR);
      byte_q.push_back(CH_LF);
    end
    if (nlines > 0) begin
      byte_q.push_back(CH_CR);
      byte_q.push_back(CH_LF);
    end
    if ($urandom_range(1)) begin
      add_text("OK");
    end else begin
      add_text("ERROR");
    end
    byte_q.push_back(CH_CR);
    byte_q.push_back(CH_LF);
    if (corrupt) begin
      pos = $urandom_range(first, byte_q.size() - 1);
      byte_q[pos] = noise_char();
    end
  endtask

  task build_stimulus();
    int roll;
    add_crlf();
    add_text("OK");
    add_crlf();
    add_crlf();
    add_text("ERROR");
    add_crlf();
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    add_crlf();
    byte_q.push_back(CH_PLUS);
    byte_q.push_back(CH_LF);
    add_crlf();
    add_text("X");
    add_reply(17, 1'b0, 1'b0);
    add_reply(2, 1'b1, 1'b0);
    while (byte_q.size() < 400) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        repeat ($urandom_range(1, 4)) byte_q.push_back(noise_char());
      end else begin
        add_reply(($urandom_range(99) < 4) ? $urandom_range(15, 17) : $urandom_range(0, 4),
                  1'b0, $urandom_range(99) < 10);
      end
    end
  endtask

  task send_all();
    foreach (byte_q[i]) begin
      @(negedge clk);
      while (!(i >= 150 && i < 250) && $urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      rx_byte <= byte_q[i];
      do @(posedge clk); while (in_stall);
      sb.note_byte(byte_q[i]);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // receiver: random stall, one long hold-off, one stretch with no stall
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held && results_seen >= 60) begin
        held = 1'b1;
        hold_left = 50;
        out_stall <= 1'b1;
      end else if (results_seen >= 200 && results_seen < 300) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 14);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {status, store_write, store_line, store_column, store_byte, lines_captured};
      sb.check(got);
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    results_seen = 0;
    quiet_cycles = 0;
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_all();
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
